>>> hdl/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam int SYMS_PER_JOB = 4;

  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // all characters caused by one input byte
  typedef struct packed {
    sym_t [SYMS_PER_JOB-1:0] syms;
    logic [1:0]              last_idx;
    logic                    msg_end;
  } job_t;

  function automatic logic [7:0] encode_sym(input sym_t s);
    logic [7:0] v;
    logic [7:0] ch;
    v = {2'b00, s.val};
    case (v) inside
      [8'd0:8'd25]:  ch = v + 8'h41;
      [8'd26:8'd51]: ch = v + 8'h47;   // 'a' - 26
      [8'd52:8'd61]: ch = v - 8'd4;    // '0' - 52
      8'd62:         ch = 8'h2b;
      default:       ch = 8'h2f;
    endcase
    if (s.pad) begin
      ch = PAD_CHAR;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hdl/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_message,
  output b64e_pkg::job_t       job,
  output logic [1:0]           phase
);

  logic [3:0] carry;
  logic [1:0] phase_next;
  logic [3:0] carry_next;

  always_comb begin
    job = '0;
    phase_next = b64e_pkg::PHASE_SECOND;
    carry_next = {2'b00, data_byte[1:0]};
    case (phase)
      b64e_pkg::PHASE_SECOND: begin
        job.syms[0].val = {carry[1:0], data_byte[7:4]};
        phase_next = b64e_pkg::PHASE_THIRD;
        carry_next = data_byte[3:0];
      end
      b64e_pkg::PHASE_THIRD: begin
        job.syms[0].val = {carry, data_byte[7:6]};
        job.syms[1].val = data_byte[5:0];
        job.last_idx = 2'd1;
        phase_next = b64e_pkg::PHASE_FIRST;
        carry_next = '0;
      end
      default: begin  // unused phase code acts as start of group
        job.syms[0].val = data_byte[7:2];
      end
    endcase

    if (end_of_message) begin
      job.msg_end = 1'b1;
      if (phase_next == b64e_pkg::PHASE_SECOND) begin
        job.syms[1].val = {carry_next[1:0], 4'b0000};
        job.syms[2].pad = 1'b1;
        job.syms[3].pad = 1'b1;
        job.last_idx = 2'd3;
      end else if (phase_next == b64e_pkg::PHASE_THIRD) begin
        job.syms[1].val = {carry_next, 2'b00};
        job.syms[2].pad = 1'b1;
        job.last_idx = 2'd2;
      end
      phase_next = b64e_pkg::PHASE_FIRST;
      carry_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= b64e_pkg::PHASE_FIRST;
      carry <= '0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/b64e_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_job_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire b64e_pkg::job_t  wr_job,
  output logic                 full,
  input  wire logic            rd_en,
  output b64e_pkg::job_t       rd_job,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64e_pkg::job_t  job,
  input  wire logic            job_valid,
  output logic                 job_done,
  output logic [1:0]           idx,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output logic                 empty,
  input  wire logic            pop
);

  logic out_valid;
  logic advance;
  logic at_end;

  assign empty    = !out_valid;
  assign advance  = job_valid && (!out_valid || pop);
  assign at_end   = (idx == job.last_idx);
  assign job_done = advance && at_end;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= b64e_pkg::encode_sym(job.syms[idx]);
      out_last <= job.msg_end && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/base64_encoder_core.sv
// A taken byte is stored as one job in the queue; its characters are then registered
// in turn in the back end's character register. Throughput: one character per cycle
// out of the back end while the receiver keeps popping; a byte yields 1 to 4
// characters, so the single character register sets the sustained rate. A short job
// queue lets the front take bytes during bursts. Reset (rst, synchronous): group
// position and leftover bits clear, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module base64_encoder_core #(
  parameter int JOB_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char,
  output logic            out_last
);

  b64e_pkg::job_t new_job;
  b64e_pkg::job_t head_job;
  logic           accept;
  logic           q_empty;
  logic           job_done;
  logic [1:0]     phase;
  logic [1:0]     idx;

  assign accept = push && !full;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (new_job),
    .phase          (phase)
  );

  b64e_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (new_job),
    .full   (full),
    .rd_en  (job_done),
    .rd_job (head_job),
    .empty  (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_valid (!q_empty),
    .job_done  (job_done),
    .idx       (idx),
    .out_char  (out_char),
    .out_last  (out_last),
    .empty     (empty),
    .pop       (pop)
  );

  // end of message always leaves the front at the start of a group
  a_eom_resets_phase: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_message |=> phase == b64e_pkg::PHASE_FIRST)
    else $error("group position not cleared after end of message");

  // character index stays within the head job
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= head_job.last_idx)
    else $error("character index past end of job");

  // a partly sent job cannot vanish from the queue
  a_idx_needs_job: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> !q_empty)
    else $error("character index set with no job queued");

  // the unused phase code is never entered
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("group position reached unused code");

endmodule

`default_nettype wire

>>> verif/base64_encoder_core_tb.sv
`timescale 1ns / 1ps

module base64_encoder_core_tb;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Tracks the encoder state and the characters still owed on the output.
  class char_scoreboard;
    logic [1:0]  phase;
    logic [3:0]  carry;
    enc_char_t   owed_q[$];
    int          errors;
    string       alphabet;

    function new();
      phase    = b64e_pkg::PHASE_FIRST;
      carry    = 4'd0;
      errors   = 0;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function logic [7:0] to_ascii(input logic [5:0] v);
      return alphabet[v];
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_byte(input logic [7:0] b, input logic eom);
      logic [7:0] chars [4];
      int n;
      n = 0;
      case (phase)
        b64e_pkg::PHASE_SECOND: begin
          chars[n++] = to_ascii({carry[1:0], b[7:4]});
          carry = b[3:0];
          phase = b64e_pkg::PHASE_THIRD;
        end
        b64e_pkg::PHASE_THIRD: begin
          chars[n++] = to_ascii({carry, b[7:6]});
          chars[n++] = to_ascii(b[5:0]);
          carry = 4'd0;
          phase = b64e_pkg::PHASE_FIRST;
        end
        default: begin
          chars[n++] = to_ascii(b[7:2]);
          carry = {2'b00, b[1:0]};
          phase = b64e_pkg::PHASE_SECOND;
        end
      endcase
      if (eom) begin
        // flush the partial sextet, then pad the group out to four
        if (phase == b64e_pkg::PHASE_SECOND) begin
          chars[n++] = to_ascii({carry[1:0], 4'b0000});
          chars[n++] = b64e_pkg::PAD_CHAR;
          chars[n++] = b64e_pkg::PAD_CHAR;
        end else if (phase == b64e_pkg::PHASE_THIRD) begin
          chars[n++] = to_ascii({carry, 2'b00});
          chars[n++] = b64e_pkg::PAD_CHAR;
        end
        phase = b64e_pkg::PHASE_FIRST;
        carry = 4'd0;
      end
      for (int i = 0; i < n; i++) begin
        owed_q.push_back('{ch: chars[i], last: eom && (i == n - 1)});
      end
    endfunction

    task check_char(input logic [7:0] ch, input logic last);
      enc_char_t exp_c;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected word char=%h last=%b", ch, last));
      end else begin
        exp_c = owed_q.pop_front();
        if (ch !== exp_c.ch) begin
          report($sformatf("out_char %h, want %h", ch, exp_c.ch));
        end
        if (last !== exp_c.last) begin
          report($sformatf("out_last %b, want %b (char %h)", last, exp_c.last, exp_c.ch));
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       out_last;

  char_scoreboard sb;
  int  bytes_in;
  int  burst_left;
  logic hold;

  base64_encoder_core dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input logic eom);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1:    gap = 0;
        9:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 3);
      endcase
      repeat (gap) begin
        @(negedge clk);
        push = 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    push           = 1'b1;
    data_byte      = b;
    end_of_message = eom;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b, eom);
    bytes_in++;
    burst_left--;
  endtask

  task automatic push_msg(input logic [7:0] msg [$]);
    foreach (msg[i]) push_byte(msg[i], i == msg.size() - 1);
  endtask

  // receiver: stall mode is picked anew at random intervals
  initial begin
    int rx_mode;
    int rx_count;
    logic ready;
    rx_mode  = 0;
    rx_count = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_char(out_char, out_last);
      @(negedge clk);
      if (rx_count == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_count = $urandom_range(20, 80);
      end
      rx_count--;
      case (rx_mode)
        0:       ready = 1'b1;
        1:       ready = rx_count[0];
        2:       ready = 1'($urandom_range(0, 1));
        default: ready = ($urandom_range(0, 3) == 0);
      endcase
      pop = ready && !hold;
    end
  end

  // long receiver hold-off so the block backs up and asserts full
  initial begin
    hold = 1'b0;
    wait (bytes_in >= 60);
    @(negedge clk);
    hold = 1'b1;
    repeat (200) @(posedge clk);
    @(negedge clk);
    hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int len;
    int rand_bytes;
    logic [7:0] msg [$];
    sb             = new();
    rst            = 1'b1;
    push           = 1'b0;
    pop            = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    bytes_in       = 0;
    burst_left     = 1000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // one byte left over, two left over, full groups, longer messages
    push_msg('{8'h00});
    push_msg('{8'hff});
    push_msg('{8'hff, 8'hff});
    push_msg('{8'h00, 8'h00, 8'h00});
    push_msg('{8'hfb, 8'hef, 8'hbe});
    push_msg('{8'hff, 8'hff, 8'hff});
    push_msg('{8'h80, 8'h7f, 8'h01, 8'hfe});
    push_msg('{8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h96});

    burst_left = 0;
    rand_bytes = 0;
    while (rand_bytes < 285) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      push_msg(msg);
      rand_bytes += len;
    end

    @(negedge clk);
    push = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_job_fifo.sv
hdl/b64e_back.sv
hdl/base64_encoder_core.sv
verif/base64_encoder_core_tb.sv
